### design/lrm_pkg.sv
// Shared definitions for the lazy range-add / range-max tree.
// Operation codes, default sizing and the engine status bundle.
// No dependencies.
`default_nettype none

package lrm_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int DATA_W     = 32;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;

  // What a parent frame does once its child call returns.
  typedef enum logic [1:0] {
    PH_ONLY  = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2
  } lrm_phase_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } lrm_status_t;

endpackage

`default_nettype wire

### design/lrm_node_ram.sv
// Single-port-write, single-port-read node store with registered read data.
// Depends on nothing.
`default_nettype none

module lrm_node_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/lrm_engine.sv
// Tree walk sequencer: clearing pass, explicit call stack and read-modify-write
// of node maxima and pending adds held in two external node RAMs.
// Depends on lrm_pkg.
`default_nettype none

module lrm_engine
  import lrm_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF,
  parameter int NODES  = 2 * LEAVES,
  parameter int AW     = $clog2(NODES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        op,
  input  wire logic [10:0]       range_start,
  input  wire logic [10:0]       range_end,
  input  wire logic [9:0]        position,
  input  wire logic [DATA_W-1:0] amount,
  input  wire logic              res_take,
  output lrm_status_t            status,
  output logic [DATA_W-1:0]      res_max,
  output logic                   res_err,
  output logic                   max_we,
  output logic [AW-1:0]          max_waddr,
  output logic [DATA_W-1:0]      max_wdata,
  output logic [AW-1:0]          max_raddr,
  input  wire logic [DATA_W-1:0] max_rdata,
  output logic                   pend_we,
  output logic [AW-1:0]          pend_waddr,
  output logic [DATA_W-1:0]      pend_wdata,
  output logic [AW-1:0]          pend_raddr,
  input  wire logic [DATA_W-1:0] pend_rdata
);

  localparam int PW  = $clog2(LEAVES + 1);
  localparam int SD  = $clog2(LEAVES) + 1;
  localparam int SPW = $clog2(SD + 1);
  localparam int SIW = $clog2(SD);

  typedef enum logic [16:0] {
    S_CLR     = 17'h00001,
    S_IDLE    = 17'h00002,
    S_ENTER   = 17'h00004,
    S_NODE_RD = 17'h00008,
    S_NODE_WR = 17'h00010,
    S_PD0     = 17'h00020,
    S_PD1     = 17'h00040,
    S_PD2     = 17'h00080,
    S_PD3     = 17'h00100,
    S_PD4     = 17'h00200,
    S_DESC    = 17'h00400,
    S_RET     = 17'h00800,
    S_RESUME  = 17'h01000,
    S_PU0     = 17'h02000,
    S_PU1     = 17'h04000,
    S_PU2     = 17'h08000,
    S_RES     = 17'h10000
  } state_t;

  typedef struct packed {
    logic [AW-1:0]     k;
    logic [PW-1:0]     lo;
    logic [PW-1:0]     hi;
    logic [PW-1:0]     s;
    logic [PW-1:0]     e;
    lrm_phase_t        phase;
    logic [DATA_W-1:0] acc;
  } frame_t;

  state_t            state_r, state_nxt;
  frame_t            stack_r [SD];
  logic [SPW-1:0]    sp_r;
  logic [SPW-1:0]    sp_m1;
  logic [AW-1:0]     clr_cnt_r;
  logic [1:0]        op_r;
  logic [DATA_W-1:0] v_r;
  logic [PW-1:0]     p_r;
  logic [AW-1:0]     k_r;
  logic [PW-1:0]     lo_r, hi_r, s_r, e_r;
  lrm_phase_t        phase_r;
  logic [DATA_W-1:0] acc_r, ret_r, pd_r, tmp_r;
  logic              err_r;
  logic [PW:0]       lohi;
  logic [PW-1:0]     mid;
  logic [AW-1:0]     k2, k2p1;
  logic              full, leaf, go_left, split, bad;

  assign lohi  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid   = lohi[PW:1];
  assign k2    = {k_r[AW-2:0], 1'b0};
  assign k2p1  = {k_r[AW-2:0], 1'b1};
  assign full  = (s_r == lo_r) && (e_r == hi_r);
  assign leaf  = (hi_r - lo_r) <= PW'(1);
  assign sp_m1 = sp_r - SPW'(1);
  assign bad   = (range_start >= range_end) || (32'(range_end) > 32'(LEAVES));

  always_comb begin
    split   = 1'b0;
    go_left = 1'b0;
    if (op_r == OP_RAISE) begin
      go_left = p_r < mid;
    end else if (e_r <= mid) begin
      go_left = 1'b1;
    end else if (s_r < mid) begin
      split = 1'b1;
    end
  end

  assign status.idle      = (state_r == S_IDLE);
  assign status.res_valid = (state_r == S_RES);
  assign res_max          = ret_r;
  assign res_err          = err_r;

  // RAM port steering; every read is issued one state ahead of its use.
  always_comb begin
    max_we     = 1'b0;
    pend_we    = 1'b0;
    max_waddr  = k_r;
    pend_waddr = k_r;
    max_wdata  = '0;
    pend_wdata = '0;
    max_raddr  = k_r;
    pend_raddr = k_r;
    unique case (state_r)
      S_CLR: begin
        max_we     = 1'b1;
        pend_we    = 1'b1;
        max_waddr  = clr_cnt_r;
        pend_waddr = clr_cnt_r;
      end
      S_NODE_WR: begin
        if (op_r == OP_ADD) begin
          max_we     = 1'b1;
          pend_we    = 1'b1;
          max_wdata  = max_rdata + v_r;
          pend_wdata = pend_rdata + v_r;
        end else if (op_r == OP_RAISE) begin
          max_we    = $signed(v_r) > $signed(max_rdata);
          max_wdata = v_r;
        end
      end
      S_PD1: begin
        pend_we    = 1'b1;
        max_raddr  = k2;
        pend_raddr = k2;
      end
      S_PD2: begin
        max_we     = 1'b1;
        pend_we    = 1'b1;
        max_waddr  = k2;
        pend_waddr = k2;
        max_wdata  = max_rdata + pd_r;
        pend_wdata = pend_rdata + pd_r;
      end
      S_PD3: begin
        max_raddr  = k2p1;
        pend_raddr = k2p1;
      end
      S_PD4: begin
        max_we     = 1'b1;
        pend_we    = 1'b1;
        max_waddr  = k2p1;
        pend_waddr = k2p1;
        max_wdata  = max_rdata + pd_r;
        pend_wdata = pend_rdata + pd_r;
      end
      S_PU0: max_raddr = k2;
      S_PU1: max_raddr = k2p1;
      S_PU2: begin
        max_we    = 1'b1;
        max_wdata = ($signed(tmp_r) > $signed(max_rdata)) ? tmp_r : max_rdata;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (clr_cnt_r == AW'(NODES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (op == OP_QUERY) begin
            state_nxt = bad ? S_RES : S_ENTER;
          end else if (op == OP_ADD && !bad) begin
            state_nxt = S_ENTER;
          end else if (op == OP_RAISE && 32'(position) < 32'(LEAVES)) begin
            state_nxt = S_ENTER;
          end
        end
      end
      S_ENTER:   state_nxt = ((op_r == OP_RAISE) ? leaf : full) ? S_NODE_RD : S_PD0;
      S_NODE_RD: state_nxt = S_NODE_WR;
      S_NODE_WR: state_nxt = S_RET;
      S_PD0:     state_nxt = S_PD1;
      S_PD1:     state_nxt = S_PD2;
      S_PD2:     state_nxt = S_PD3;
      S_PD3:     state_nxt = S_PD4;
      S_PD4:     state_nxt = S_DESC;
      S_DESC:    state_nxt = S_ENTER;
      S_RET: begin
        if (sp_r != '0) begin
          state_nxt = S_RESUME;
        end else begin
          state_nxt = (op_r == OP_QUERY) ? S_RES : S_IDLE;
        end
      end
      S_RESUME: begin
        if (phase_r == PH_LEFT) begin
          state_nxt = S_ENTER;
        end else begin
          state_nxt = (op_r == OP_QUERY) ? S_RET : S_PU0;
        end
      end
      S_PU0:     state_nxt = S_PU1;
      S_PU1:     state_nxt = S_PU2;
      S_PU2:     state_nxt = S_RET;
      S_RES:     if (res_take) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      sp_r      <= '0;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_CLR: clr_cnt_r <= clr_cnt_r + AW'(1);
        S_IDLE: begin
          op_r    <= op;
          v_r     <= amount;
          p_r     <= PW'(position);
          s_r     <= PW'(range_start);
          e_r     <= PW'(range_end);
          lo_r    <= '0;
          hi_r    <= PW'(LEAVES);
          k_r     <= AW'(1);
          sp_r    <= '0;
          acc_r   <= '0;
          ret_r   <= '0;
          err_r   <= (op == OP_QUERY) && bad;
        end
        S_NODE_WR: ret_r <= max_rdata;
        S_PD1:     pd_r  <= pend_rdata;
        S_DESC: begin
          stack_r[sp_r[SIW-1:0]] <= '{k: k_r, lo: lo_r, hi: hi_r, s: s_r, e: e_r,
                                      phase: split ? PH_LEFT : PH_ONLY, acc: acc_r};
          sp_r <= sp_r + SPW'(1);
          if (split || go_left) begin
            k_r  <= k2;
            hi_r <= mid;
            if (split) e_r <= mid;
          end else begin
            k_r  <= k2p1;
            lo_r <= mid;
          end
        end
        S_RET: begin
          if (sp_r != '0) begin
            k_r     <= stack_r[sp_m1[SIW-1:0]].k;
            lo_r    <= stack_r[sp_m1[SIW-1:0]].lo;
            hi_r    <= stack_r[sp_m1[SIW-1:0]].hi;
            s_r     <= stack_r[sp_m1[SIW-1:0]].s;
            e_r     <= stack_r[sp_m1[SIW-1:0]].e;
            phase_r <= stack_r[sp_m1[SIW-1:0]].phase;
            acc_r   <= stack_r[sp_m1[SIW-1:0]].acc;
            sp_r    <= sp_m1;
          end
        end
        S_RESUME: begin
          if (phase_r == PH_LEFT) begin
            // Left half done: remember its maximum and walk the right half.
            stack_r[sp_r[SIW-1:0]] <= '{k: k_r, lo: lo_r, hi: hi_r, s: s_r, e: e_r,
                                        phase: PH_RIGHT, acc: ret_r};
            sp_r  <= sp_r + SPW'(1);
            acc_r <= ret_r;
            k_r   <= k2p1;
            lo_r  <= mid;
            s_r   <= mid;
          end else if (phase_r == PH_RIGHT) begin
            if ($signed(acc_r) > $signed(ret_r)) ret_r <= acc_r;
          end
        end
        S_PU1:   tmp_r <= max_rdata;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/lazy_range_add_range_max_tree.sv
// Top level of the lazy range-add / range-maximum tree.
// Depends on lrm_pkg, lrm_node_ram and lrm_engine.
`default_nettype none

// The block keeps a balanced binary tree over LEAVES signed 32-bit elements,
// all zero after reset, and takes one transaction at a time: a range add of
// in_amount over [in_range_start, in_range_end), a range maximum query over
// the same kind of range, or a raise of element in_position to at least
// in_amount. Only a query returns a result transaction; an empty or
// out-of-bounds query returns zero with out_range_error set, while bad adds,
// out-of-range raises and operation code 3 are taken and dropped. Values wrap
// as two's complement. Node maxima and pending adds live in two synchronous
// RAMs of 2*LEAVES entries (4*LEAVES when LEAVES is not a power of two).
// After reset a clearing pass writes zero to every node, one node per cycle,
// and in_stall stays high meanwhile. The walk is done by one sequencer with
// a call stack; every node step is a read followed in the next state by its
// write, so no access can overlap another to the same entry. On a partially
// covered node the walk pushes its pending add to both children (S_PD0 to
// S_PD4) on the way down and recomputes its maximum (S_PU0 to S_PU2) on the
// way back, plus the call and return states. An add or query whose range
// splits visits up to two partially covered and two fully covered nodes per
// level; a query recomputes no maxima, so it skips S_PU0 to S_PU2 on a
// partially covered node. The result is held in an output register, so the
// next transaction is taken while a query result still waits on out_stall.
module lazy_range_add_range_max_tree
  import lrm_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [10:0]        in_range_start,
  input  wire logic [10:0]        in_range_end,
  input  wire logic [9:0]         in_position,
  input  wire logic signed [31:0] in_amount,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_max_value,
  output logic                    out_range_error
);

  localparam int NODES = ((LEAVES & (LEAVES - 1)) == 0) ? 2 * LEAVES : 4 * LEAVES;
  localparam int AW    = $clog2(NODES);

  lrm_status_t       status;
  logic [DATA_W-1:0] res_max;
  logic              res_err;
  logic              res_take;
  logic              start;
  logic              max_we, pend_we;
  logic [AW-1:0]     max_waddr, pend_waddr, max_raddr, pend_raddr;
  logic [DATA_W-1:0] max_wdata, pend_wdata, max_rdata, pend_rdata;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_max_r;
  logic              out_err_r;

  // Input side is open whenever the sequencer sits idle.
  assign in_stall = !status.idle;
  assign start    = in_valid && !in_stall;

  // The output register frees up when empty or when its transaction leaves.
  assign res_take = !out_valid_r || !out_stall;

  lrm_engine #(
    .LEAVES (LEAVES),
    .NODES  (NODES),
    .AW     (AW)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .op          (in_operation),
    .range_start (in_range_start),
    .range_end   (in_range_end),
    .position    (in_position),
    .amount      (in_amount),
    .res_take    (res_take),
    .status      (status),
    .res_max     (res_max),
    .res_err     (res_err),
    .max_we      (max_we),
    .max_waddr   (max_waddr),
    .max_wdata   (max_wdata),
    .max_raddr   (max_raddr),
    .max_rdata   (max_rdata),
    .pend_we     (pend_we),
    .pend_waddr  (pend_waddr),
    .pend_wdata  (pend_wdata),
    .pend_raddr  (pend_raddr),
    .pend_rdata  (pend_rdata)
  );

  lrm_node_ram #(.DEPTH(NODES), .AW(AW), .DW(DATA_W)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (max_waddr),
    .wdata (max_wdata),
    .raddr (max_raddr),
    .rdata (max_rdata)
  );

  lrm_node_ram #(.DEPTH(NODES), .AW(AW), .DW(DATA_W)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (status.res_valid && res_take) begin
        out_valid_r <= 1'b1;
        out_max_r   <= res_max;
        out_err_r   <= res_err;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_max_value   = out_max_r;
  assign out_range_error = out_err_r;

endmodule

`default_nettype wire
